// ===== src/complex_arithmetic_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared assertion shorthands for the checker of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define CAU_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Word types, command codes and fixed widths shared by the unit's modules.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_PART_WIDTH    = 16;
    localparam int CAU_FRACTION_BITS = 8;
    // Three front stages, one stage per quotient bit, one output stage.
    localparam int CAU_LATENCY       = CAU_PART_WIDTH + 4;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef logic signed [CAU_PART_WIDTH-1:0] part_t;

    typedef struct packed {
        cmd_t  command;
        part_t a_real;
        part_t a_imag;
        part_t b_real;
        part_t b_imag;
    } in_word_t;

    typedef struct packed {
        part_t result_real;
        part_t result_imag;
        logic  overflow;
        logic  divide_by_zero;
    } out_word_t;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } div_ctrl_t;

endpackage

// ===== src/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Products, sums, direct results and divider set-up over three stages.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
#(
    parameter int FRACTION_BITS = CAU_FRACTION_BITS
)
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    input  in_word_t                                        in_word,
    output div_ctrl_t                                       ctrl,
    output out_word_t                                       direct,
    output logic [3*CAU_PART_WIDTH+FRACTION_BITS+1:0]       rem_re,
    output logic [3*CAU_PART_WIDTH+FRACTION_BITS+1:0]       rem_im,
    output logic [2*CAU_PART_WIDTH:0]                       den
);

    localparam int W  = CAU_PART_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int DW = 2 * W + 1;
    localparam int XW = 3 * W + FRACTION_BITS + 2;

    localparam logic signed [SW-1:0] SAT_MAX = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};

    // Stage 1 registers.
    logic                 valid1_reg;
    cmd_t                 cmd1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_r_reg, p_bb_i_reg;
    logic signed [W:0]    as_re_reg, as_im_reg;
    logic signed [W:0]    as_re_next, as_im_next;

    // Stage 2 registers.
    logic                 valid2_reg;
    cmd_t                 cmd2_reg;
    logic signed [SW-1:0] sum_re_reg, sum_im_reg, sum_re_next, sum_im_next;
    logic [DW-1:0]        den2_reg;

    // Stage 3 registers.
    div_ctrl_t            ctrl_reg, ctrl_next;
    out_word_t            direct_reg, direct_next;
    logic [XW-1:0]        rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [DW-1:0]        den_reg;

    function automatic logic [SW:0] sat_wide(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] s;
        logic                 o;
        s = v;
        o = 1'b0;
        if (v > SAT_MAX)
        begin
            s = SAT_MAX;
            o = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            s = SAT_MIN;
            o = 1'b1;
        end
        return {o, s};
    endfunction

    always_comb
    begin
        if (in_word.command == CMD_SUB)
        begin
            as_re_next = (W + 1)'(in_word.a_real) - (W + 1)'(in_word.b_real);
            as_im_next = (W + 1)'(in_word.a_imag) - (W + 1)'(in_word.b_imag);
        end
        else
        begin
            as_re_next = (W + 1)'(in_word.a_real) + (W + 1)'(in_word.b_real);
            as_im_next = (W + 1)'(in_word.a_imag) + (W + 1)'(in_word.b_imag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            ctrl_reg   <= '0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            ctrl_reg   <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg   <= in_word.command;
        p_rr_reg   <= in_word.a_real * in_word.b_real;
        p_ii_reg   <= in_word.a_imag * in_word.b_imag;
        p_ri_reg   <= in_word.a_real * in_word.b_imag;
        p_ir_reg   <= in_word.a_imag * in_word.b_real;
        p_bb_r_reg <= in_word.b_real * in_word.b_real;
        p_bb_i_reg <= in_word.b_imag * in_word.b_imag;
        as_re_reg  <= as_re_next;
        as_im_reg  <= as_im_next;

        cmd2_reg   <= cmd1_reg;
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
        den2_reg   <= DW'($unsigned(p_bb_r_reg)) + DW'($unsigned(p_bb_i_reg));

        direct_reg <= direct_next;
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        den_reg    <= den2_reg;
    end

    always_comb
    begin
        unique case (cmd1_reg)
            CMD_MUL:
            begin
                sum_re_next = SW'(p_rr_reg) - SW'(p_ii_reg);
                sum_im_next = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            CMD_DIV:
            begin
                sum_re_next = SW'(p_rr_reg) + SW'(p_ii_reg);
                sum_im_next = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
            default:
            begin
                sum_re_next = SW'(as_re_reg);
                sum_im_next = SW'(as_im_reg);
            end
        endcase
    end

    always_comb
    begin
        logic [SW-1:0]        mag_re, mag_im;
        logic [XW-1:0]        limit;
        logic signed [SW-1:0] v_re, v_im;
        logic [SW:0]          s_re, s_im;

        mag_re = sum_re_reg[SW-1] ? SW'(-sum_re_reg) : SW'(sum_re_reg);
        mag_im = sum_im_reg[SW-1] ? SW'(-sum_im_reg) : SW'(sum_im_reg);
        rem_re_next = XW'(mag_re) << FRACTION_BITS;
        rem_im_next = XW'(mag_im) << FRACTION_BITS;
        // The quotient cannot fit the part when numerator reaches den * 2^W.
        limit = XW'(den2_reg) << W;

        ctrl_next.valid  = valid2_reg;
        ctrl_next.is_div = (cmd2_reg == CMD_DIV);
        ctrl_next.dz     = (den2_reg == '0);
        ctrl_next.neg_re = sum_re_reg[SW-1];
        ctrl_next.neg_im = sum_im_reg[SW-1];
        ctrl_next.ovf_re = (rem_re_next >= limit);
        ctrl_next.ovf_im = (rem_im_next >= limit);

        if (cmd2_reg == CMD_MUL)
        begin
            v_re = sum_re_reg >>> FRACTION_BITS;
            v_im = sum_im_reg >>> FRACTION_BITS;
        end
        else
        begin
            v_re = sum_re_reg;
            v_im = sum_im_reg;
        end
        s_re = sat_wide(v_re);
        s_im = sat_wide(v_im);
        direct_next.result_real    = s_re[W-1:0];
        direct_next.result_imag    = s_im[W-1:0];
        direct_next.overflow       = s_re[SW] | s_im[SW];
        direct_next.divide_by_zero = 1'b0;
    end

    assign ctrl   = ctrl_reg;
    assign direct = direct_reg;
    assign rem_re = rem_re_reg;
    assign rem_im = rem_im_reg;
    assign den    = den_reg;

endmodule

// ===== src/cau_div_step.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider step
// One registered restoring step that settles one quotient bit of both parts.
// ----------------------------------------------------------------------------
module cau_div_step
    import cau_pkg::*;
#(
    parameter int FRACTION_BITS = CAU_FRACTION_BITS,
    parameter int SHIFT         = 0
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  div_ctrl_t                                 ctrl_in,
    input  out_word_t                                 direct_in,
    input  logic [3*CAU_PART_WIDTH+FRACTION_BITS+1:0] rem_re_in,
    input  logic [3*CAU_PART_WIDTH+FRACTION_BITS+1:0] rem_im_in,
    input  logic [2*CAU_PART_WIDTH:0]                 den_in,
    input  logic [CAU_PART_WIDTH-1:0]                 q_re_in,
    input  logic [CAU_PART_WIDTH-1:0]                 q_im_in,
    output div_ctrl_t                                 ctrl_out,
    output out_word_t                                 direct_out,
    output logic [3*CAU_PART_WIDTH+FRACTION_BITS+1:0] rem_re_out,
    output logic [3*CAU_PART_WIDTH+FRACTION_BITS+1:0] rem_im_out,
    output logic [2*CAU_PART_WIDTH:0]                 den_out,
    output logic [CAU_PART_WIDTH-1:0]                 q_re_out,
    output logic [CAU_PART_WIDTH-1:0]                 q_im_out
);

    localparam int W  = CAU_PART_WIDTH;
    localparam int XW = 3 * W + FRACTION_BITS + 2;

    div_ctrl_t     ctrl_reg;
    out_word_t     direct_reg;
    logic [XW-1:0] rem_re_reg, rem_im_reg, rem_re_next, rem_im_next, dshift;
    logic [2*W:0]  den_reg;
    logic [W-1:0]  q_re_reg, q_im_reg, q_re_next, q_im_next;

    always_comb
    begin
        dshift      = XW'(den_in) << SHIFT;
        rem_re_next = rem_re_in;
        rem_im_next = rem_im_in;
        q_re_next   = q_re_in;
        q_im_next   = q_im_in;
        if (rem_re_in >= dshift)
        begin
            rem_re_next      = rem_re_in - dshift;
            q_re_next[SHIFT] = 1'b1;
        end
        if (rem_im_in >= dshift)
        begin
            rem_im_next      = rem_im_in - dshift;
            q_im_next[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        direct_reg <= direct_in;
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        den_reg    <= den_in;
        q_re_reg   <= q_re_next;
        q_im_reg   <= q_im_next;
    end

    assign ctrl_out   = ctrl_reg;
    assign direct_out = direct_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;
    assign den_out    = den_reg;
    assign q_re_out   = q_re_reg;
    assign q_im_out   = q_im_reg;

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, subtract, multiply and divide of signed fixed-point complex
// numbers with saturation, overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Usage: drive a command word on operands and raise start; the word is taken
// at every rising edge where start is high and busy is low. busy never rises,
// so a new word may be issued in every cycle.
// Each word yields one result word. done is high for exactly one cycle with
// the result on result, after the word has passed three front stages
// (products, sums, divider set-up), one restoring divider stage per
// quotient bit, and the output register. Throughput is one word per cycle
// for every command. Results leave in issue order. The receiver cannot
// stall, so nothing is held back: the pipeline advances in every cycle.
// Reset clears every valid bit at once; words in flight are dropped and
// done stays low until new words come through.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRACTION_BITS = CAU_FRACTION_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  operands,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    localparam int W  = CAU_PART_WIDTH;
    localparam int XW = 3 * W + FRACTION_BITS + 2;

    // Chain between divider steps; index k feeds step k.
    div_ctrl_t     ctrl_chain   [0:W];
    out_word_t     direct_chain [0:W];
    logic [XW-1:0] rem_re_chain [0:W];
    logic [XW-1:0] rem_im_chain [0:W];
    logic [2*W:0]  den_chain    [0:W];
    logic [W-1:0]  q_re_chain   [0:W];
    logic [W-1:0]  q_im_chain   [0:W];

    logic          done_reg;
    out_word_t     result_reg, result_next;

    cau_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_word  (operands),
        .ctrl     (ctrl_chain[0]),
        .direct   (direct_chain[0]),
        .rem_re   (rem_re_chain[0]),
        .rem_im   (rem_im_chain[0]),
        .den      (den_chain[0])
    );

    assign q_re_chain[0] = '0;
    assign q_im_chain[0] = '0;

    // Quotient bits are settled from the top bit down, one per stage.
    for (genvar k = 0; k < W; k++)
    begin : g_div
        cau_div_step #(
            .FRACTION_BITS (FRACTION_BITS),
            .SHIFT         (W - 1 - k)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl_in    (ctrl_chain[k]),
            .direct_in  (direct_chain[k]),
            .rem_re_in  (rem_re_chain[k]),
            .rem_im_in  (rem_im_chain[k]),
            .den_in     (den_chain[k]),
            .q_re_in    (q_re_chain[k]),
            .q_im_in    (q_im_chain[k]),
            .ctrl_out   (ctrl_chain[k+1]),
            .direct_out (direct_chain[k+1]),
            .rem_re_out (rem_re_chain[k+1]),
            .rem_im_out (rem_im_chain[k+1]),
            .den_out    (den_chain[k+1]),
            .q_re_out   (q_re_chain[k+1]),
            .q_im_out   (q_im_chain[k+1])
        );
    end

    // Applies the sign to a quotient magnitude and saturates it. The top bit
    // of the returned value is the saturation flag.
    function automatic logic [W:0] sat_quot(input logic [W-1:0] q, input logic neg,
                                            input logic big);
        logic [W-1:0] v;
        logic         o;
        o = 1'b0;
        if (neg)
        begin
            if (big || (q[W-1] && (|q[W-2:0])))
            begin
                v = {1'b1, {(W - 1){1'b0}}};
                o = 1'b1;
            end
            else
                v = W'(-q);
        end
        else
        begin
            if (big || q[W-1])
            begin
                v = {1'b0, {(W - 1){1'b1}}};
                o = 1'b1;
            end
            else
                v = q;
        end
        return {o, v};
    endfunction

    always_comb
    begin
        logic [W:0] s_re, s_im;
        div_ctrl_t  c;

        c    = ctrl_chain[W];
        s_re = sat_quot(q_re_chain[W], c.neg_re, c.ovf_re);
        s_im = sat_quot(q_im_chain[W], c.neg_im, c.ovf_im);
        priority if (!c.is_div)
            result_next = direct_chain[W];
        else if (c.dz)
        begin
            result_next.result_real    = '0;
            result_next.result_imag    = '0;
            result_next.overflow       = 1'b0;
            result_next.divide_by_zero = 1'b1;
        end
        else
        begin
            result_next.result_real    = s_re[W-1:0];
            result_next.result_imag    = s_im[W-1:0];
            result_next.overflow       = s_re[W] | s_im[W];
            result_next.divide_by_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl_chain[W].valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/cau_checker.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level checks on timing and flags, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module cau_checker
    import cau_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input in_word_t  operands,
    input logic      busy,
    input logic      done,
    input out_word_t result
);

    logic dz_flag;
    logic dz_clean;
    logic div_cmd;

    // A zero-divisor result carries zero parts and no overflow.
    assign dz_flag  = done && result.divide_by_zero;
    assign dz_clean = !result.overflow && (result.result_real == '0)
                      && (result.result_imag == '0);
    assign div_cmd  = (operands.command == CMD_DIV);

    `CAU_NEVER(a_never_busy, busy, "busy rose although the pipeline never stalls")
    `CAU_ASSERT(a_latency, (start && !busy) |-> ##CAU_LATENCY done, "accepted word gave no result")
    `CAU_ASSERT(a_no_orphan, done |-> $past(start && !busy, CAU_LATENCY), "result without a word")
    `CAU_NEVER(a_dz_clean, dz_flag && !dz_clean, "bad divide-by-zero result")
    `CAU_ASSERT(a_dz_cmd, dz_flag |-> $past(div_cmd, CAU_LATENCY), "divide-by-zero off a divide")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
);
